@@ rtl/lir_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Shared constants and the sequencer state type of the resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

   // Default widths of a sample and of the fraction of a source position.
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   // Integer bits of the step register and of the internal positions.
   localparam int STEP_INT_BITS = 5;

   // Entries of the queue between the front and the engine.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HELD,
      ST_LOOP,
      ST_LOOP_ADD,
      ST_TAIL,
      ST_FINISH
   } lir_state_type;

endpackage

@@ rtl/lir_queue.sv @@
// ----------------------------------------------------------------------------
// Resampler item queue
// Small first-in first-out buffer between the front and the engine.
// ----------------------------------------------------------------------------
module lir_queue #(
   parameter int WIDTH = 18,
   parameter int DEPTH = lir_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + IW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + IW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/lir_front.sv @@
// ----------------------------------------------------------------------------
// Resampler front end
// Accepts input beats, marks the first sample of each block and queues them.
// ----------------------------------------------------------------------------
module lir_front #(
   parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                   req_end_of_stream,
   output logic                   q_push,
   output logic [SAMPLE_BITS+1:0] q_wr_data,
   input  logic                   q_full
);

   logic have_prev_ff, have_prev_in;
   logic accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   // Packed as first-of-block flag, end-of-stream flag, sample.
   assign q_wr_data = {!have_prev_ff, req_end_of_stream, req_sample_in};

   always_comb begin
      have_prev_in = have_prev_ff;
      if (csr_we) begin
         have_prev_in = 1'b0;
      end else if (accept) begin
         have_prev_in = !req_end_of_stream;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

@@ rtl/lir_engine.sv @@
// ----------------------------------------------------------------------------
// Resampler engine
// Sequencer that interpolates the outputs of one queued sample at a time and
// delivers them through a one-result lookahead and an output register.
// ----------------------------------------------------------------------------
module lir_engine #(
   parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS,
   parameter int FRAC_BITS   = lir_pkg::FRAC_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_we,
   input  logic [FRAC_BITS+lir_pkg::STEP_INT_BITS-1:0] step,
   input  logic                                       q_not_empty,
   input  logic [SAMPLE_BITS+1:0]                     q_rd_data,
   output logic                                       q_pop,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [SAMPLE_BITS-1:0]                     rsp_sample_out,
   output logic                                       rsp_run_last
);

   localparam int SB = SAMPLE_BITS;
   localparam int FB = FRAC_BITS;
   localparam int PW = FB + lir_pkg::STEP_INT_BITS;
   localparam int MW = SB + FB + 2;
   localparam logic [PW-1:0] ONE  = PW'(64'd1 << FB);
   localparam logic [PW-1:0] TWO  = PW'(64'd2 << FB);
   localparam logic [MW-1:0] HALF = MW'(64'd1 << (FB - 1));

   lir_pkg::lir_state_type state_ff, state_in;

   logic [PW-1:0]        np_ff, np_in;
   logic [SB-1:0]        prev_ff, prev_in;
   logic                 held_valid_ff, held_valid_in;
   logic [SB-1:0]        held_value_ff, held_value_in;
   logic [PW-1:0]        held_short_ff, held_short_in;
   logic [SB-1:0]        cur_ff, cur_in;
   logic                 eos_ff, eos_in;
   logic                 first_ff, first_in;
   logic signed [MW-1:0] mult_ff, mult_in;

   logic                 pend_valid_ff, pend_valid_in;
   logic [SB-1:0]        pend_value_ff, pend_value_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]        rsp_sample_ff, rsp_sample_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 out_free, can_emit, push;
   logic                 emit_go, done_go;
   logic [SB-1:0]        emit_value;
   logic signed [SB:0]   diff;
   logic signed [FB:0]   frac;
   logic signed [MW-1:0] rounded;
   logic [SB+1:0]        interp_wide;
   logic [SB-1:0]        interp;
   logic [PW:0]          reach;
   logic [PW:0]          tail_sum;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_emit = !pend_valid_ff || out_free;

   assign diff  = $signed({cur_ff[SB-1], cur_ff}) - $signed({prev_ff[SB-1], prev_ff});
   assign frac  = $signed({1'b0, np_ff[FB-1:0]});

   // Halves round towards plus infinity: add one half, then shift arithmetically.
   assign rounded     = (mult_ff + $signed(HALF)) >>> FB;
   assign interp_wide = {{2{prev_ff[SB-1]}}, prev_ff} + rounded[SB+1:0];
   assign interp      = interp_wide[SB-1:0];

   assign reach    = {1'b0, np_ff} + {1'b0, step};
   assign tail_sum = reach;

   always_comb begin
      state_in      = state_ff;
      np_in         = np_ff;
      prev_in       = prev_ff;
      held_valid_in = held_valid_ff;
      held_value_in = held_value_ff;
      held_short_in = held_short_ff;
      cur_in        = cur_ff;
      eos_in        = eos_ff;
      first_in      = first_ff;
      mult_in       = mult_ff;
      emit_go       = 1'b0;
      emit_value    = cur_ff;
      done_go       = 1'b0;
      q_pop         = 1'b0;

      case (state_ff)
         lir_pkg::ST_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_rd_data[SB-1:0];
               eos_in   = q_rd_data[SB];
               first_in = q_rd_data[SB+1];
               state_in = lir_pkg::ST_HELD;
            end
         end
         lir_pkg::ST_HELD: begin
            // The held result is settled before the new sample is used.
            if (held_valid_ff && (held_short_ff <= ONE)) begin
               if (can_emit) begin
                  emit_go       = 1'b1;
                  emit_value    = held_value_ff;
                  held_valid_in = 1'b0;
                  state_in      = first_ff ? lir_pkg::ST_TAIL : lir_pkg::ST_LOOP;
               end
            end else begin
               if (held_valid_ff) begin
                  if (eos_ff) begin
                     held_valid_in = 1'b0;
                  end else begin
                     held_short_in = held_short_ff - ONE;
                  end
               end
               state_in = first_ff ? lir_pkg::ST_TAIL : lir_pkg::ST_LOOP;
            end
         end
         lir_pkg::ST_LOOP: begin
            if (np_ff < ONE) begin
               mult_in  = diff * frac;
               state_in = lir_pkg::ST_LOOP_ADD;
            end else begin
               np_in    = np_ff - ONE;
               state_in = lir_pkg::ST_TAIL;
            end
         end
         lir_pkg::ST_LOOP_ADD: begin
            if (reach <= {1'b0, TWO}) begin
               if (can_emit) begin
                  emit_go    = 1'b1;
                  emit_value = interp;
                  np_in      = reach[PW-1:0];
                  state_in   = lir_pkg::ST_LOOP;
               end
            end else if (eos_ff) begin
               // Beyond the count at the end of the block: dropped.
               state_in = lir_pkg::ST_FINISH;
            end else begin
               held_valid_in = 1'b1;
               held_value_in = interp;
               held_short_in = reach[PW-1:0] - TWO;
               np_in         = reach[PW-1:0];
               state_in      = lir_pkg::ST_LOOP;
            end
         end
         lir_pkg::ST_TAIL: begin
            if (eos_ff) begin
               if (tail_sum <= {1'b0, ONE}) begin
                  if (can_emit) begin
                     emit_go    = 1'b1;
                     emit_value = cur_ff;
                     np_in      = tail_sum[PW-1:0];
                  end
               end else begin
                  state_in = lir_pkg::ST_FINISH;
               end
            end else begin
               prev_in  = cur_ff;
               state_in = lir_pkg::ST_FINISH;
            end
         end
         lir_pkg::ST_FINISH: begin
            if (can_emit) begin
               done_go = 1'b1;
               if (eos_ff) begin
                  np_in         = '0;
                  prev_in       = '0;
                  held_valid_in = 1'b0;
               end
               state_in = lir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lir_pkg::ST_IDLE;
         end
      endcase

      if (csr_we) begin
         np_in         = '0;
         prev_in       = '0;
         held_valid_in = 1'b0;
         held_short_in = '0;
      end
   end

   // One result is kept back until the next one or the end of the item shows
   // whether it is the last of its input.
   always_comb begin
      push          = (emit_go || done_go) && pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = pend_value_ff;
         rsp_last_in   = done_go;
      end
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      if (emit_go) begin
         pend_valid_in = 1'b1;
         pend_value_in = emit_value;
      end else if (done_go) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lir_pkg::ST_IDLE;
         np_ff         <= '0;
         prev_ff       <= '0;
         held_valid_ff <= 1'b0;
         held_short_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         np_ff         <= np_in;
         prev_ff       <= prev_in;
         held_valid_ff <= held_valid_in;
         held_short_ff <= held_short_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_value_ff <= held_value_in;
      cur_ff        <= cur_in;
      eos_ff        <= eos_in;
      first_ff      <= first_in;
      mult_ff       <= mult_in;
      pend_value_ff <= pend_value_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_run_last   = rsp_last_ff;

   a_frac_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == lir_pkg::ST_LOOP_ADD |-> np_ff < ONE)
      else $error("interpolation position not below one sample");

   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      state_ff == lir_pkg::ST_IDLE |-> !pend_valid_ff)
      else $error("result still pending between items");

   a_held_bounded: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> held_short_ff < (ONE << 4))
      else $error("held shortfall out of range");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !held_valid_ff && np_ff == '0)
      else $error("step write did not clear the stream state");

endmodule

@@ rtl/linear_interp_resampler.sv @@
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Sample rate converter that interpolates between neighbouring samples at
// positions spaced by a programmable 5.16 step.
// ----------------------------------------------------------------------------
//   channel   direction  ports                                 handshake
//   req       in         req_sample_in, req_end_of_stream      valid / stall
//   rsp       out        rsp_sample_out, rsp_run_last          valid / stall
//   csr       in         csr_step                              write enable
//
// The engine works on one queued sample at a time. Each interpolated output
// passes first through the multiplier and then through the rounding add,
// and the final sample of an ended block is repeated as the step allows.
// Reset is synchronous; it clears the stream state and sets the step to one.
// A two-entry queue lets the front take samples while the engine works, and
// the engine waits to emit while a result is pending and the output is stalled.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
   parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS,
   parameter int FRAC_BITS   = lir_pkg::FRAC_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_we,
   input  logic [FRAC_BITS+lir_pkg::STEP_INT_BITS-1:0] csr_step,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [SAMPLE_BITS-1:0]               req_sample_in,
   input  logic                                        req_end_of_stream,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]               rsp_sample_out,
   output logic                                        rsp_run_last
);

   localparam int PW = FRAC_BITS + lir_pkg::STEP_INT_BITS;
   localparam logic [PW-1:0] ONE      = PW'(64'd1 << FRAC_BITS);
   localparam logic [PW-1:0] STEP_MIN = ONE >> 3;
   localparam logic [PW-1:0] STEP_MAX = ONE << 4;

   logic [PW-1:0]          step_ff, step_in;
   logic                   q_push, q_pop, q_full, q_not_empty;
   logic [SAMPLE_BITS+1:0] q_wr_data, q_rd_data;
   logic [SAMPLE_BITS-1:0] sample_out;

   // The step is stored already clamped to the range from one eighth to sixteen.
   always_comb begin
      step_in = step_ff;
      if (csr_we) begin
         if (csr_step < STEP_MIN) begin
            step_in = STEP_MIN;
         end else if (csr_step > STEP_MAX) begin
            step_in = STEP_MAX;
         end else begin
            step_in = csr_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ONE;
      end else begin
         step_ff <= step_in;
      end
   end

   lir_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_in     (req_sample_in),
      .req_end_of_stream (req_end_of_stream),
      .q_push            (q_push),
      .q_wr_data         (q_wr_data),
      .q_full            (q_full)
   );

   lir_queue #(
      .WIDTH(SAMPLE_BITS + 2),
      .DEPTH(lir_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_data   (q_wr_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .rd_data   (q_rd_data)
   );

   lir_engine #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .step           (step_ff),
      .q_not_empty    (q_not_empty),
      .q_rd_data      (q_rd_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (sample_out),
      .rsp_run_last   (rsp_run_last)
   );

   assign rsp_sample_out = $signed(sample_out);

endmodule

@@ tb/sv/linear_interp_resampler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear interpolation resampler testbench
// Sends blocks of signed samples under a range of step settings, predicts
// every resampled beat with an in-bench model of the converter and checks
// each beat from the block against the oldest prediction. Both channels idle
// at random, and one long receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
module linear_interp_resampler_tb;

   localparam int SAMPLE_BITS = lir_pkg::SAMPLE_BITS;
   localparam int FRAC_BITS = lir_pkg::FRAC_BITS;
   localparam int STEP_BITS = FRAC_BITS + lir_pkg::STEP_INT_BITS;
   localparam logic [31:0] ONE_POS = 32'd1 << FRAC_BITS;
   localparam logic [31:0] STEP_FLOOR = ONE_POS >> 3;
   localparam logic [31:0] STEP_CEILING = ONE_POS * 16;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_SAMPLES = 165;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          run_last;
   } resampled_beat_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   logic [STEP_BITS-1:0]          csr_step = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          req_end_of_stream = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_run_last;

   // Converter state as the bench sees it.
   logic [STEP_BITS-1:0]          step_setting = STEP_BITS'(ONE_POS);
   logic signed [SAMPLE_BITS-1:0] last_sample;
   logic                          have_last;
   logic [31:0]                   next_pos;
   logic                          held_valid;
   logic signed [SAMPLE_BITS-1:0] held_value;
   logic [31:0]                   held_shortfall;

   resampled_beat_type outputs_due[$];
   int error_count = 0;
   int samples_sent = 0;
   int idle_percent = 36;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;

   linear_interp_resampler DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_step          (csr_step),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_in     (req_sample_in),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_run_last      (rsp_run_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_stream();
      last_sample = '0;
      have_last = 1'b0;
      next_pos = '0;
      held_valid = 1'b0;
      held_value = '0;
      held_shortfall = '0;
   endfunction

   // Interpolation between a and b, with halves rounded towards plus infinity.
   function automatic logic signed [SAMPLE_BITS-1:0] blend(
      input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b,
      input logic [31:0]                   frac
   );
      longint t;
      t = (longint'(b) - longint'(a)) * longint'(frac) + longint'(ONE_POS >> 1);
      return SAMPLE_BITS'(longint'(a) + (t >>> FRAC_BITS));
   endfunction

   function automatic void resample_one(input logic signed [SAMPLE_BITS-1:0] cur,
                                        input logic eos);
      logic [31:0]                   st;
      logic [31:0]                   reach;
      logic                          dropped;
      logic signed [SAMPLE_BITS-1:0] v;
      logic signed [SAMPLE_BITS-1:0] produced[$];
      st = 32'(step_setting);
      dropped = 1'b0;
      if (st < STEP_FLOOR) st = STEP_FLOOR;
      if (st > STEP_CEILING) st = STEP_CEILING;

      if (held_valid) begin
         if (held_shortfall <= ONE_POS) begin
            produced.push_back(held_value);
            held_valid = 1'b0;
         end else if (eos) begin
            held_valid = 1'b0;
         end else begin
            held_shortfall = held_shortfall - ONE_POS;
         end
      end

      if (have_last) begin
         while (!dropped && next_pos < ONE_POS) begin
            v = blend(last_sample, cur, next_pos);
            reach = next_pos + st;
            if (reach <= 2 * ONE_POS) begin
               produced.push_back(v);
            end else if (eos) begin
               dropped = 1'b1;
            end else begin
               // Whether this one is kept depends on samples still to come.
               held_valid = 1'b1;
               held_value = v;
               held_shortfall = reach - 2 * ONE_POS;
            end
            if (!dropped) next_pos = next_pos + st;
         end
         if (!dropped) next_pos = next_pos - ONE_POS;
      end

      if (eos) begin
         if (!dropped) begin
            while (next_pos + st <= ONE_POS) begin
               produced.push_back(cur);
               next_pos = next_pos + st;
            end
         end
         clear_stream();
      end else begin
         last_sample = cur;
         have_last = 1'b1;
      end

      foreach (produced[i])
         outputs_due.push_back('{sample_out: produced[i],
                                 run_last: (i == produced.size() - 1)});
   endfunction

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_percent);
      end
   end

   // A beat shown at the falling edge is taken at the next rising edge.
   always @(negedge clock) begin
      resampled_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outputs_due.size() == 0) begin
            $error("unexpected beat: sample_out %0d run_last %0b",
                   rsp_sample_out, rsp_run_last);
            error_count++;
         end else begin
            want = outputs_due.pop_front();
            if (rsp_sample_out !== want.sample_out) begin
               $error("sample_out: expected %0d, actual %0d",
                      want.sample_out, rsp_sample_out);
               error_count++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %0b, actual %0b",
                      want.run_last, rsp_run_last);
               error_count++;
            end
         end
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] sample,
                              input logic eos);
      logic taken;
      while ($urandom_range(99) < idle_percent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= sample;
      req_end_of_stream <= eos;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      resample_one(sample, eos);
      samples_sent++;
   endtask

   // Samples that give no beat may still be in the block, so allow it time.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(input logic [STEP_BITS-1:0] value);
      wait_for_drain();
      csr_we <= 1'b1;
      csr_step <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      step_setting = value;
      clear_stream();
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(9))
         0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [STEP_BITS-1:0] random_step();
      case ($urandom_range(7))
         0: return STEP_BITS'(STEP_FLOOR);
         1: return STEP_BITS'(STEP_CEILING);
         2: return STEP_BITS'($urandom_range(STEP_FLOOR, ONE_POS));
         3: return STEP_BITS'($urandom);
         default: return STEP_BITS'($urandom_range(STEP_FLOOR, 4 * ONE_POS));
      endcase
   endfunction

   // Step of one straight out of reset, with the sample extremes.
   task automatic test_unity_step();
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shFFFF, 1'b1);
   endtask

   // A lone sample with end of stream gives floor(ratio) copies of itself.
   task automatic test_single_sample_blocks();
      write_step(STEP_BITS'(STEP_FLOOR));
      send_sample(16'sh7FFF, 1'b1);
      write_step(STEP_BITS'(4 * ONE_POS));
      send_sample(16'sh8000, 1'b1);
   endtask

   task automatic test_step_limits();
      // Zero is taken as one eighth and all ones as sixteen.
      write_step('0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      write_step('1);
      send_sample(16'sd100, 1'b0);
      send_sample(16'sd200, 1'b0);
      send_sample(16'sd300, 1'b1);
      // With a step of three a held beat is released once, then one is
      // dropped at the end of the block.
      write_step(STEP_BITS'(3 * ONE_POS));
      send_sample(16'sd10, 1'b0);
      send_sample(16'sd20, 1'b0);
      send_sample(16'sd30, 1'b0);
      send_sample(16'sd40, 1'b0);
      send_sample(16'sd50, 1'b1);
   endtask

   // A step write part way through a block starts a fresh block.
   task automatic test_mid_stream_write();
      write_step(STEP_BITS'(ONE_POS + (ONE_POS >> 1)));
      send_sample(-16'sd1000, 1'b0);
      send_sample(16'sd2500, 1'b0);
      send_sample(-16'sd7, 1'b0);
      write_step(STEP_BITS'((ONE_POS >> 2) * 3));
      send_sample(16'sd1234, 1'b0);
      send_sample(-16'sd4321, 1'b1);
   endtask

   task automatic test_random_streams();
      int start_count;
      int block_len;
      logic ended;
      start_count = samples_sent;
      while (samples_sent < start_count + RANDOM_SAMPLES) begin
         write_step(random_step());
         idle_percent = ($urandom_range(3) == 0) ? 0 : 36;
         repeat ($urandom_range(1, 3)) begin
            block_len = $urandom_range(1, 12);
            // Now and then a block is left open; the next step write discards it.
            ended = ($urandom_range(7) != 0);
            for (int i = 0; i < block_len; i++)
               send_sample(random_sample(), ended && (i == block_len - 1));
         end
      end
      idle_percent = 36;
   endtask

   // The receiver holds off while beats keep coming, so the block stalls its input.
   task automatic test_backpressure();
      write_step(STEP_BITS'(STEP_FLOOR));
      idle_percent = 0;
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 24; i++)
         send_sample(random_sample(), i == 23);
      idle_percent = 36;
   endtask

   initial begin
      clear_stream();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_unity_step();
      test_single_sample_blocks();
      test_step_limits();
      test_mid_stream_write();
      test_random_streams();
      test_backpressure();
      wait_for_drain();
      if (error_count == 0 && outputs_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
